// ----- src/lcv_pkg.sv -----
// ----------------------------------------------------------------------------
// lcv_pkg
// Shared types, constants and digit helpers for the Luhn card number checker.
// ----------------------------------------------------------------------------
package lcv_pkg;

  // saturation point of the digit counter
  localparam int MAX_DIGITS = 31;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

  localparam int DIGIT_W  = 4;
  localparam int LEN_W    = 5;
  localparam int PREFIX_W = 7;
  localparam int TYPE_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_A_LENGTH        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_A_PREFIX        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_B_LENGTH        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_B_PREFIX_FIRST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_B_PREFIX_SECOND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_C_LENGTH        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_C_PREFIX        = 3'd6;

  // card type codes
  localparam logic [TYPE_W-1:0] CARD_UNKNOWN = 2'd0;
  localparam logic [TYPE_W-1:0] CARD_TYPE_A  = 2'd1;
  localparam logic [TYPE_W-1:0] CARD_TYPE_B  = 2'd2;
  localparam logic [TYPE_W-1:0] CARD_TYPE_C  = 2'd3;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last_digit;
  } in_item_t;

  typedef struct packed {
    logic [TYPE_W-1:0] card_type;
    logic              card_valid;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]    type_a_length;
    logic [PREFIX_W-1:0] type_a_prefix;
    logic [LEN_W-1:0]    type_b_length;
    logic [PREFIX_W-1:0] type_b_prefix_first;
    logic [PREFIX_W-1:0] type_b_prefix_second;
    logic [LEN_W-1:0]    type_c_length;
    logic [PREFIX_W-1:0] type_c_prefix;
  } cfg_regs_t;

  // digit taken mod 10 as is
  function automatic logic [DIGIT_W-1:0] plain_mod10(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = (d > 4'd9) ? d - 4'd10 : d;
    return r;
  endfunction

  // doubled digit with its decimal digits summed, then mod 10
  function automatic logic [DIGIT_W-1:0] double_mod10(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    case (d)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd2;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd6;
      4'd4:    r = 4'd8;
      4'd5:    r = 4'd1;
      4'd6:    r = 4'd3;
      4'd7:    r = 4'd5;
      4'd8:    r = 4'd7;
      4'd9:    r = 4'd9;
      4'd10:   r = 4'd2;
      4'd11:   r = 4'd4;
      4'd12:   r = 4'd6;
      4'd13:   r = 4'd8;
      4'd14:   r = 4'd0;
      4'd15:   r = 4'd3;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // sum of two values below ten, mod 10
  function automatic logic [DIGIT_W-1:0] add_mod10(input logic [DIGIT_W-1:0] a,
                                                   input logic [DIGIT_W-1:0] b);
    logic [DIGIT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > 5'd9) begin
      s = s - 5'd10;
    end
    return s[DIGIT_W-1:0];
  endfunction

endpackage

// ----- src/lcv_acc.sv -----
// ----------------------------------------------------------------------------
// lcv_acc
// Luhn accumulator: running sums for both count parities, digit count,
// prefix capture and card classification on the final digit.
// ----------------------------------------------------------------------------
module lcv_acc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  lcv_pkg::in_item_t item,
  input  lcv_pkg::cfg_regs_t cfg,
  output lcv_pkg::out_item_t result
);

  logic [lcv_pkg::DIGIT_W-1:0] sum_even_r, sum_even_nxt;
  logic [lcv_pkg::DIGIT_W-1:0] sum_odd_r, sum_odd_nxt;
  logic [lcv_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [lcv_pkg::DIGIT_W-1:0] lead_r, lead_nxt;
  logic [lcv_pkg::DIGIT_W-1:0] second_r, second_nxt;

  logic [lcv_pkg::DIGIT_W-1:0] plain_val;
  logic [lcv_pkg::DIGIT_W-1:0] dbl_val;
  logic [7:0]                  prefix;
  logic                        prefix_ok;
  logic                        match_a, match_b, match_c;
  logic [lcv_pkg::DIGIT_W-1:0] final_sum;

  assign plain_val = lcv_pkg::plain_mod10(item.digit);
  assign dbl_val   = lcv_pkg::double_mod10(item.digit);

  always_comb begin
    lead_nxt   = (count_r == '0) ? item.digit : lead_r;
    second_nxt = (count_r == lcv_pkg::CNT_W'(1)) ? item.digit : second_r;
    // even-position digits from the left are doubled if the final count is even
    if (!count_r[0]) begin
      sum_even_nxt = lcv_pkg::add_mod10(sum_even_r, dbl_val);
      sum_odd_nxt  = lcv_pkg::add_mod10(sum_odd_r, plain_val);
    end else begin
      sum_even_nxt = lcv_pkg::add_mod10(sum_even_r, plain_val);
      sum_odd_nxt  = lcv_pkg::add_mod10(sum_odd_r, dbl_val);
    end
    if (count_r != lcv_pkg::CNT_W'(lcv_pkg::MAX_DIGITS)) begin
      count_nxt = count_r + lcv_pkg::CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  // classification from the updated state
  assign prefix    = {lead_nxt, 3'b000} + {3'b000, lead_nxt, 1'b0} + {4'b0000, second_nxt};
  assign prefix_ok = (count_nxt >= lcv_pkg::CNT_W'(2)) && (lead_nxt <= 4'd9) &&
                     (second_nxt <= 4'd9);

  assign match_a = prefix_ok &&
                   (count_nxt == lcv_pkg::CNT_W'(cfg.type_a_length)) &&
                   (prefix == {1'b0, cfg.type_a_prefix});
  assign match_b = prefix_ok &&
                   (count_nxt == lcv_pkg::CNT_W'(cfg.type_b_length)) &&
                   ((prefix == {1'b0, cfg.type_b_prefix_first}) ||
                    (prefix == {1'b0, cfg.type_b_prefix_second}));
  assign match_c = prefix_ok &&
                   (count_nxt == lcv_pkg::CNT_W'(cfg.type_c_length)) &&
                   (prefix == {1'b0, cfg.type_c_prefix});

  assign final_sum = count_nxt[0] ? sum_odd_nxt : sum_even_nxt;

  always_comb begin
    if (match_a) begin
      result.card_type = lcv_pkg::CARD_TYPE_A;
    end else if (match_b) begin
      result.card_type = lcv_pkg::CARD_TYPE_B;
    end else if (match_c) begin
      result.card_type = lcv_pkg::CARD_TYPE_C;
    end else begin
      result.card_type = lcv_pkg::CARD_UNKNOWN;
    end
    result.card_valid = (match_a || match_b || match_c) && (final_sum == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_even_r <= '0;
      sum_odd_r  <= '0;
      count_r    <= '0;
      lead_r     <= '0;
      second_r   <= '0;
    end else if (step) begin
      if (item.last_digit) begin
        // number finished, start over
        sum_even_r <= '0;
        sum_odd_r  <= '0;
        count_r    <= '0;
        lead_r     <= '0;
        second_r   <= '0;
      end else begin
        sum_even_r <= sum_even_nxt;
        sum_odd_r  <= sum_odd_nxt;
        count_r    <= count_nxt;
        lead_r     <= lead_nxt;
        second_r   <= second_nxt;
      end
    end
  end

endmodule

// ----- src/luhn_card_number_validator_top.sv -----
// ----------------------------------------------------------------------------
// luhn_card_number_validator_top
// Streams card number digits, checks the Luhn sum and classifies the card.
// ----------------------------------------------------------------------------
//  channel  | ports                           | moves
//  ---------+---------------------------------+-------------------------------
//  input    | in_valid, in_ready, in_data     | one digit and last flag
//  result   | out_valid, out_ready, out_data  | card type and valid, per number
//  config   | cfg_we, cfg_index, cfg_wdata    | one register write per cycle
//
//  one digit per cycle; a digit waits in the input register until stepped, and
//  that step loads the result of a last digit into the output register.
//  the input register frees whenever the output register is empty or being
//  taken, so transfers continue back to back while the result side keeps up.
//  sync reset clears the handshake and the running sums and loads the default
//  card types.
module luhn_card_number_validator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lcv_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lcv_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [lcv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcv_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  lcv_pkg::cfg_regs_t cfg_r;
  lcv_pkg::in_item_t  stage_r;
  logic               stage_valid_r;
  lcv_pkg::out_item_t out_r;
  logic               out_valid_r;
  lcv_pkg::out_item_t result;
  logic               out_free;
  logic               step;

  assign out_free = !out_valid_r || out_ready;
  assign step     = stage_valid_r && out_free;
  assign in_ready = !stage_valid_r || out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  lcv_acc u_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (stage_r),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.type_a_length        <= 5'd14;
      cfg_r.type_a_prefix        <= 7'd65;
      cfg_r.type_b_length        <= 5'd16;
      cfg_r.type_b_prefix_first  <= 7'd77;
      cfg_r.type_b_prefix_second <= 7'd78;
      cfg_r.type_c_length        <= 5'd15;
      cfg_r.type_c_prefix        <= 7'd91;
    end else if (cfg_we) begin
      case (cfg_index)
        lcv_pkg::CFG_TYPE_A_LENGTH:        cfg_r.type_a_length <= cfg_wdata[4:0];
        lcv_pkg::CFG_TYPE_A_PREFIX:        cfg_r.type_a_prefix <= cfg_wdata;
        lcv_pkg::CFG_TYPE_B_LENGTH:        cfg_r.type_b_length <= cfg_wdata[4:0];
        lcv_pkg::CFG_TYPE_B_PREFIX_FIRST:  cfg_r.type_b_prefix_first <= cfg_wdata;
        lcv_pkg::CFG_TYPE_B_PREFIX_SECOND: cfg_r.type_b_prefix_second <= cfg_wdata;
        lcv_pkg::CFG_TYPE_C_LENGTH:        cfg_r.type_c_length <= cfg_wdata[4:0];
        lcv_pkg::CFG_TYPE_C_PREFIX:        cfg_r.type_c_prefix <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ready) begin
      stage_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r <= in_data;
    end
  end

  // output register, loaded only by a last digit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && stage_r.last_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && stage_r.last_digit) begin
      out_r <= result;
    end
  end

endmodule
